// File: hw/rtl/puew_pkg.sv
// Shared types, constants and fixed-point helpers for the phase unwrap edge weight block.
// No dependencies.
`default_nettype none

package puew_pkg;

	localparam int PI_Q     = 12868;
	localparam int TWO_PI_Q = 25736;

	localparam logic [16:0] ONE_Q16         = 17'd65536;
	localparam logic [15:0] TENTH_Q16       = 16'd6554;
	localparam logic [15:0] NINE_TENTHS_Q16 = 16'd58982;

	localparam int ADDR_W = 4;

	// Mode bits of the weight_modes register
	localparam int MODE_PHASE = 0;
	localparam int MODE_GRAD  = 1;
	localparam int MODE_LIN   = 2;
	localparam int MODE_MAG   = 3;

	typedef enum logic [1:0] {
		REG_MODES = 2'd0,
		REG_RATIO = 2'd1,
		REG_MAGP  = 2'd2
	} puew_reg_t;

	typedef struct packed {
		logic [3:0]  modes;
		logic [15:0] ratio;
		logic        mag_on;
	} puew_cfg_t;

	typedef struct packed {
		logic        ok;
		logic [16:0] w;
	} puew_side_t;

	// Q1.16 product, round half up
	function automatic logic [16:0] mul_q16(logic [16:0] a, logic [16:0] b);
		logic [33:0] p;
		p = 34'(a) * 34'(b) + 34'd32768;
		return p[32:16];
	endfunction

	// 0.1 + 0.9*q in Q1.16
	function automatic logic [16:0] factor(logic [16:0] q);
		logic [32:0] p;
		p = 33'(q) * 33'(NINE_TENTHS_Q16) + 33'd32768;
		return 17'(TENTH_Q16) + p[32:16];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/puew_if.sv
// Valid/ready channel interfaces for the edge word and the bin word.
// Depends on nothing.
`default_nettype none

interface puew_in_if #(parameter int MAGNITUDE_BITS = 16);
	logic                      valid;
	logic                      ready;
	logic                      edge_valid;
	logic signed [15:0]        phase_here;
	logic signed [15:0]        phase_next;
	logic signed [15:0]        phase_before;
	logic signed [15:0]        phase_after;
	logic                      outer_present;
	logic signed [15:0]        second_phase_here;
	logic signed [15:0]        second_phase_next;
	logic [MAGNITUDE_BITS-1:0] magnitude_here;
	logic [MAGNITUDE_BITS-1:0] magnitude_next;

	modport source (output valid, edge_valid, phase_here, phase_next, phase_before,
		phase_after, outer_present, second_phase_here, second_phase_next,
		magnitude_here, magnitude_next, input ready);
	modport sink (input valid, edge_valid, phase_here, phase_next, phase_before,
		phase_after, outer_present, second_phase_here, second_phase_next,
		magnitude_here, magnitude_next, output ready);
endinterface

interface puew_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] weight_bin;

	modport source (output valid, weight_bin, input ready);
	modport sink (input valid, weight_bin, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/phase_unwrap_edge_weight.sv
// Edge weight for phase unwrapping, from input accept to output valid.
// Throughput one edge word per cycle while the enable is high; the whole pipeline advances on one enable, which
// drops only while the output register holds a word that the sink has not taken.
// Stages: 8 in the phase front, 18 in the divider (a load stage, then one quotient bit per stage), 4 in the tail.
// arst_n clears all valid bits and loads register defaults (modes 13, ratio 2048, mag off).
// Depends on puew_pkg, puew_if, puew_cfg, puew_phase, puew_div, puew_tail.
`default_nettype none

module phase_unwrap_edge_weight #(
	parameter int BIN_COUNT      = 256,
	parameter int MAGNITUDE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	puew_in_if.sink                         din,
	puew_out_if.source                      dout,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [puew_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);
	import puew_pkg::*;

	puew_cfg_t                 cfg;
	logic                      adv;

	// front to divider
	logic                      ph_vld;
	puew_side_t                ph_side;
	logic [MAGNITUDE_BITS-1:0] ph_sm, ph_bg;

	// divider to tail
	logic                      dv_vld;
	puew_side_t                dv_side;
	logic [16:0]               dv_quo;

	puew_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Wrap phases, build the three phase-derived factors and multiply them.
	puew_phase #(.MB(MAGNITUDE_BITS)) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.din    (din),
		.vld    (ph_vld),
		.side   (ph_side),
		.sm     (ph_sm),
		.bg     (ph_bg)
	);

	// Magnitude ratio; also clears the word's ok flag when magnitude weighting is on and both magnitudes are zero.
	puew_div #(.MB(MAGNITUDE_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.mag_on (cfg.mag_on),
		.vin    (ph_vld),
		.sin    (ph_side),
		.sm     (ph_sm),
		.bg     (ph_bg),
		.vld    (dv_vld),
		.side   (dv_side),
		.quo    (dv_quo)
	);

	// Square the ratio, apply the last factor, map to a bin; owns the stall enable.
	puew_tail #(.BIN_COUNT(BIN_COUNT)) u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.mag_on (cfg.mag_on),
		.vin    (dv_vld),
		.sin    (dv_side),
		.quo    (dv_quo),
		.adv    (adv),
		.dout   (dout)
	);

	// A delivered bin never exceeds the worst bin.
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.weight_bin <= 8'(BIN_COUNT - 1)))
		else $error("weight_bin beyond BIN_COUNT-1");

	// Hold the input while the output word waits.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.ready) |-> !din.ready)
		else $error("input taken while output stalled");

	// A mode write shows up on the next cycle.
	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[3:2] == 2'(REG_MODES)))
		|=> (cfg.modes == $past(pwdata[3:0])))
		else $error("weight_modes write lost");

endmodule

`default_nettype wire

// File: hw/rtl/puew_cfg.sv
// APB register file: weight_modes, echo_time_ratio, magnitude_present.
// Depends on puew_pkg.
`default_nettype none

module puew_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [puew_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output puew_pkg::puew_cfg_t             cfg
);
	import puew_pkg::*;

	logic [3:0]  modes_q;
	logic [15:0] ratio_q;
	logic        magp_q;
	logic        wr;
	puew_reg_t   sel;

	assign wr     = psel && penable && pwrite;
	assign sel    = puew_reg_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= 4'd13;
			ratio_q <= 16'd2048;
			magp_q  <= 1'b0;
		end else if (wr) begin
			unique case (sel)
				REG_MODES: modes_q <= pwdata[3:0];
				REG_RATIO: ratio_q <= pwdata[15:0];
				REG_MAGP:  magp_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_MODES: prdata = {28'd0, modes_q};
			REG_RATIO: prdata = {16'd0, ratio_q};
			REG_MAGP:  prdata = {31'd0, magp_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign cfg.modes  = modes_q;
	assign cfg.ratio  = ratio_q;
	assign cfg.mag_on = modes_q[MODE_MAG] && magp_q;

endmodule

`default_nettype wire

// File: hw/rtl/puew_phase.sv
// Eight-stage front: phase wraps, coherence, gradient and linearity factors, their product.
// Depends on puew_pkg and puew_if.
`default_nettype none

module puew_phase #(
	parameter int MB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire puew_pkg::puew_cfg_t  cfg,
	puew_in_if.sink                   din,
	output logic                      vld,
	output puew_pkg::puew_side_t      side,
	output logic [MB-1:0]             sm,
	output logic [MB-1:0]             bg
);
	import puew_pkg::*;

	localparam logic [30:0] K_RECIP  = 31'd652;      // 2^24 / TWO_PI_Q, rounded
	localparam logic [36:0] PC_RECIP = 37'((64'd1 << 36) / 64'd12868);

	typedef struct packed {
		logic          ok;
		logic          op;
		logic [MB-1:0] sm;
		logic [MB-1:0] bg;
	} car_t;

	logic [8:1] v_s;
	car_t       cr_s [1:8];

	// stage 1..3
	logic signed [19:0] y_s1 [4];
	logic signed [19:0] y_s2 [4];
	logic signed [3:0]  k_s2 [4];
	logic signed [14:0] g_s3 [4];
	// stage 4
	logic [13:0]        a1_s4;
	logic [16:0]        est_s4;
	logic [17:0]        mag_s4;
	logic               neg2_s4;
	logic signed [14:0] g1_s4;
	logic [16:0]        lin1_s4, lin2_s4;
	// stage 5..8
	logic [16:0]        q1_s5, q2_s5, q3_s5;
	logic [16:0]        f1_s6, f2_s6, f3_s6;
	logic [16:0]        w12_s7, f3_s7;
	logic [16:0]        w_s8;

	logic signed [19:0] y_c [4];
	logic signed [3:0]  k_c [4];
	logic signed [14:0] g_c [4];
	logic [13:0]        ab_c [4];
	logic [16:0]        lin_c [2];
	logic [36:0]        ep_c;
	logic [29:0]        mp_c;
	logic [30:0]        num_c, t_c;
	logic signed [31:0] rem_c;
	logic [16:0]        quot_c;
	logic signed [19:0] sc_c;
	logic signed [20:0] df_c;
	logic [20:0]        e_c;
	logic [12:0]        v2_c;
	car_t               cin_c;

	assign din.ready = adv;

	// differences, offset by pi for the wrap
	assign y_c[0] = 20'(din.phase_here) - 20'(din.phase_next) + 20'(PI_Q);
	assign y_c[1] = 20'(din.second_phase_here) - 20'(din.second_phase_next) + 20'(PI_Q);
	assign y_c[2] = 20'(din.phase_before) - 20'(din.phase_here) - 20'(din.phase_here)
		+ 20'(din.phase_next) + 20'(PI_Q);
	assign y_c[3] = 20'(din.phase_here) - 20'(din.phase_next) - 20'(din.phase_next)
		+ 20'(din.phase_after) + 20'(PI_Q);

	always_comb begin
		cin_c.ok = din.edge_valid;
		cin_c.op = din.outer_present;
		cin_c.sm = (din.magnitude_here < din.magnitude_next) ? din.magnitude_here
			: din.magnitude_next;
		cin_c.bg = (din.magnitude_here < din.magnitude_next) ? din.magnitude_next
			: din.magnitude_here;
	end

	for (genvar i = 0; i < 4; i++) begin : g_wrap
		logic signed [30:0] kp;
		logic signed [20:0] r0;
		logic signed [20:0] r1;
		assign kp = 31'(y_s1[i]) * $signed(K_RECIP);
		assign k_c[i] = 4'(kp >>> 24);
		assign r0 = 21'(y_s2[i]) - 21'(k_s2[i]) * 21'(TWO_PI_Q);
		always_comb begin
			if (r0 < 0) begin
				r1 = r0 + 21'(TWO_PI_Q);
			end else if (r0 >= 21'(TWO_PI_Q)) begin
				r1 = r0 - 21'(TWO_PI_Q);
			end else begin
				r1 = r0;
			end
		end
		assign g_c[i]  = 15'(r1 - 21'(PI_Q));
		assign ab_c[i] = g_s3[i][14] ? 14'(-g_s3[i]) : 14'(g_s3[i]);
	end

	for (genvar j = 0; j < 2; j++) begin : g_lin
		assign lin_c[j] = (ab_c[j+2] >= 14'd8192) ? 17'd0 : {14'(14'd8192 - ab_c[j+2]), 3'b000};
	end

	assign ep_c = 37'(ab_c[0]) * PC_RECIP + 37'(1 << 19);
	assign mp_c = 30'(ab_c[1]) * 30'(cfg.ratio) + 30'd2048;

	// phase coherence quotient correction
	assign num_c = (31'(a1_s4) << 16) + 31'd6434;
	assign t_c   = 31'(est_s4) * 31'(PI_Q);
	assign rem_c = $signed({1'b0, num_c}) - $signed({1'b0, t_c});
	always_comb begin
		if (rem_c < 0) begin
			quot_c = est_s4 - 17'd1;
		end else if (rem_c >= 32'(PI_Q)) begin
			quot_c = est_s4 + 17'd1;
		end else begin
			quot_c = est_s4;
		end
	end

	// gradient coherence
	assign sc_c = neg2_s4 ? -$signed({2'b00, mag_s4}) : $signed({2'b00, mag_s4});
	assign df_c = 21'(g1_s4) - 21'(sc_c);
	assign e_c  = df_c[20] ? 21'(-df_c) : 21'(df_c);
	assign v2_c = 13'(21'd4096 - e_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[7:1], din.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s[1] <= cin_c;
			for (int i = 2; i <= 8; i++) begin
				cr_s[i] <= cr_s[i-1];
			end
			for (int i = 0; i < 4; i++) begin
				y_s1[i] <= y_c[i];
				y_s2[i] <= y_s1[i];
				k_s2[i] <= k_c[i];
				g_s3[i] <= g_c[i];
			end
			a1_s4   <= ab_c[0];
			est_s4  <= ep_c[36:20];
			mag_s4  <= mp_c[29:12];
			neg2_s4 <= g_s3[1][14];
			g1_s4   <= g_s3[0];
			lin1_s4 <= lin_c[0];
			lin2_s4 <= lin_c[1];
			q1_s5   <= ONE_Q16 - quot_c;
			q2_s5   <= (e_c >= 21'd4096) ? 17'd0 : {v2_c, 4'b0000};
			q3_s5   <= cr_s[4].op ? mul_q16(lin1_s4, lin2_s4) : 17'(NINE_TENTHS_Q16);
			f1_s6   <= cfg.modes[MODE_PHASE] ? factor(q1_s5) : ONE_Q16;
			f2_s6   <= cfg.modes[MODE_GRAD]  ? factor(q2_s5) : ONE_Q16;
			f3_s6   <= cfg.modes[MODE_LIN]   ? factor(q3_s5) : ONE_Q16;
			w12_s7  <= mul_q16(f1_s6, f2_s6);
			f3_s7   <= f3_s6;
			w_s8    <= mul_q16(w12_s7, f3_s7);
		end
	end

	assign vld     = v_s[8];
	assign side.ok = cr_s[8].ok;
	assign side.w  = w_s8;
	assign sm      = cr_s[8].sm;
	assign bg      = cr_s[8].bg;

endmodule

`default_nettype wire

// File: hw/rtl/puew_div.sv
// Restoring divider, a load stage then one quotient bit per stage: round(small*2^16/big) over 18 stages.
// Depends on puew_pkg.
`default_nettype none

module puew_div #(
	parameter int MB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 mag_on,
	input  wire logic                 vin,
	input  wire puew_pkg::puew_side_t sin,
	input  wire logic [MB-1:0]        sm,
	input  wire logic [MB-1:0]        bg,
	output logic                      vld,
	output puew_pkg::puew_side_t      side,
	output logic [16:0]               quo
);
	import puew_pkg::*;

	localparam int QB = 17;

	logic [QB:0]     v_s;
	logic [MB-1:0]   rem_s  [QB+1];
	logic [QB-1:0]   nlo_s  [QB+1];
	logic [QB-1:0]   q_s    [QB+1];
	logic [MB-1:0]   bg_s   [QB+1];
	puew_side_t      side_s [QB+1];

	logic [MB+16:0]  n_c;
	puew_side_t      side_c;

	// numerator with half the divisor folded in for rounding
	assign n_c = {1'b0, sm, 16'd0} + (MB+17)'(bg >> 1);

	always_comb begin
		side_c    = sin;
		side_c.ok = sin.ok && !(mag_on && (bg == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[QB-1:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= n_c[MB+16:17];
			nlo_s[0]  <= n_c[16:0];
			q_s[0]    <= '0;
			bg_s[0]   <= bg;
			side_s[0] <= side_c;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_bit
		logic [MB:0] t;
		logic        ge;
		logic [MB:0] d;
		assign t  = {rem_s[j-1], nlo_s[j-1][QB-j]};
		assign ge = t >= {1'b0, bg_s[j-1]};
		assign d  = t - {1'b0, bg_s[j-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j]  <= ge ? d[MB-1:0] : t[MB-1:0];
				nlo_s[j]  <= nlo_s[j-1];
				q_s[j]    <= {q_s[j-1][QB-2:0], ge};
				bg_s[j]   <= bg_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign vld  = v_s[QB];
	assign side = side_s[QB];
	assign quo  = q_s[QB];

endmodule

`default_nettype wire

// File: hw/rtl/puew_tail.sv
// Magnitude factor, final product and bin mapping; holds the output register.
// Depends on puew_pkg and puew_if.
`default_nettype none

module puew_tail #(
	parameter int BIN_COUNT = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 mag_on,
	input  wire logic                 vin,
	input  wire puew_pkg::puew_side_t sin,
	input  wire logic [16:0]          quo,
	output logic                      adv,
	puew_out_if.source                dout
);
	import puew_pkg::*;

	localparam logic [24:0] BIN_MAX = 25'(BIN_COUNT - 1);

	logic [4:1]  v_s;
	puew_side_t  side_s1, side_s2;
	logic        ok_s3;
	logic [16:0] q4_s1, f4_s2, w_s3;
	logic [7:0]  bin_s4;

	logic [33:0] sq_c;
	logic [16:0] inv_c;
	logic [24:0] bp_c;

	assign adv  = !v_s[4] || dout.ready;
	assign sq_c = 34'(quo) * 34'(quo) + 34'd32768;

	assign inv_c = (w_s3 > ONE_Q16) ? 17'd0 : ONE_Q16 - w_s3;
	assign bp_c  = 25'(inv_c) * BIN_MAX + 25'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[3:1], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q4_s1   <= sq_c[32:16];
			side_s1 <= sin;
			f4_s2   <= mag_on ? factor(q4_s1) : ONE_Q16;
			side_s2 <= side_s1;
			w_s3    <= mul_q16(side_s2.w, f4_s2);
			ok_s3   <= side_s2.ok;
			if (!ok_s3) begin
				bin_s4 <= 8'd0;
			end else if (bp_c[24:16] == 9'd0) begin
				bin_s4 <= 8'd1;
			end else begin
				bin_s4 <= bp_c[23:16];
			end
		end
	end

	assign dout.valid      = v_s[4];
	assign dout.weight_bin = bin_s4;

endmodule

`default_nettype wire

// File: tb/phase_unwrap_edge_weight_chk.sv
// Checker for the phase unwrap edge weight block: watches both channels, predicts bins.
// Depends on puew_pkg and puew_if.
`default_nettype none

module phase_unwrap_edge_weight_chk #(
	parameter int BIN_COUNT      = 256,
	parameter int MAGNITUDE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	puew_in_if.sink   din,
	puew_out_if.sink  dout,
	input  wire logic [3:0]  modes,
	input  wire logic [15:0] ratio,
	input  wire logic        mag_on,
	output int               fail_count,
	output int               pending,
	output logic             moved
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PI_L  = 12868;
	localparam longint TPI_L = 25736;
	localparam longint ONE_L = 65536;
	localparam longint MMASK_L = (longint'(1) << MAGNITUDE_BITS) - 1;

	logic [7:0] bin_queue[$];

	function automatic longint wrap_ph(longint x);
		longint r;
		r = (x + PI_L) % TPI_L;
		if (r < 0) r += TPI_L;
		return r - PI_L;
	endfunction

	function automatic longint absl(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint mq(longint a, longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	function automatic longint fct(longint q);
		return 6554 + ((58982 * q + 32768) >>> 16);
	endfunction

	function automatic longint tri_lin(longint a, longint b, longint c);
		longint v;
		v = 8192 - absl(wrap_ph(a - 2 * b + c));
		if (v < 0) v = 0;
		return v << 3;
	endfunction

	function automatic logic [7:0] predict_bin();
		longint ph, pn, pb, pa, sh, sn, mh, mn, w, g1, g2, q, mag, sc, v, sm, bg, r, b;
		ph = longint'(din.phase_here); pn = longint'(din.phase_next);
		pb = longint'(din.phase_before); pa = longint'(din.phase_after);
		sh = longint'(din.second_phase_here); sn = longint'(din.second_phase_next);
		mh = longint'(din.magnitude_here) & MMASK_L;
		mn = longint'(din.magnitude_next) & MMASK_L;
		w = ONE_L;
		g1 = wrap_ph(ph - pn);
		if (!din.edge_valid) return 8'd0;
		if (modes[puew_pkg::MODE_PHASE]) begin
			q = ONE_L - ((absl(g1) * ONE_L + PI_L / 2) / PI_L);
			w = mq(w, fct(q));
		end
		if (modes[puew_pkg::MODE_GRAD]) begin
			g2 = wrap_ph(sh - sn);
			mag = (absl(g2) * longint'(ratio) + 2048) >>> 12;
			sc = g2 < 0 ? -mag : mag;
			v = 4096 - absl(g1 - sc);
			q = v < 0 ? 0 : v << 4;
			w = mq(w, fct(q));
		end
		if (modes[puew_pkg::MODE_LIN]) begin
			q = din.outer_present ? mq(tri_lin(pb, ph, pn), tri_lin(ph, pn, pa)) : 58982;
			w = mq(w, fct(q));
		end
		if (modes[puew_pkg::MODE_MAG] && mag_on) begin
			sm = mh < mn ? mh : mn;
			bg = mh < mn ? mn : mh;
			if (bg == 0) return 8'd0;
			r = ((sm << 16) + bg / 2) / bg;
			q = (r * r + 32768) >>> 16;
			w = mq(w, fct(q));
		end
		if (w > ONE_L) w = ONE_L;
		b = ((ONE_L - w) * (BIN_COUNT - 1) + 32768) >>> 16;
		if (b < 1) b = 1;
		return b[7:0];
	endfunction

	assign pending = bin_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			moved <= 1'b0;
		end else begin
			moved <= (din.valid && din.ready) || (dout.valid && dout.ready);
			if (din.valid && din.ready)
				bin_queue.push_back(predict_bin());
			if (dout.valid && dout.ready) begin
				if (bin_queue.size() == 0) begin
					$error("weight_bin: no word expected, actual %0d", dout.weight_bin);
					fail_count <= fail_count + 1;
				end else begin
					want = bin_queue.pop_front();
					if (dout.weight_bin !== want) begin
						$error("weight_bin: expected %0d actual %0d", want, dout.weight_bin);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

// File: tb/phase_unwrap_edge_weight_tb.sv
// Top of the phase unwrap edge weight testbench: clock, reset, APB writes and edge stimulus.
// Depends on puew_pkg, puew_if, the block and phase_unwrap_edge_weight_chk.
`default_nettype none

module phase_unwrap_edge_weight_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import puew_pkg::*;

	localparam int LATENCY = 30;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	// shadow copy of the registers, handed to the checker
	logic [3:0]  modes_shadow;
	logic [15:0] ratio_shadow;
	logic        mag_shadow;

	int src_idle_pct, snk_idle_pct;
	int fail_count, pending;
	logic moved;
	int quiet_cycles;

	puew_in_if #(.MAGNITUDE_BITS(16)) din();
	puew_out_if dout();

	phase_unwrap_edge_weight DUT (
		.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	phase_unwrap_edge_weight_chk CHK (
		.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.modes(modes_shadow), .ratio(ratio_shadow), .mag_on(mag_shadow),
		.fail_count(fail_count), .pending(pending), .moved(moved)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run once nothing has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || moved || (!din.valid && pending == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: drop ready at random at the current idle rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dout.ready <= 1'b0;
		else
			dout.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Write one register through a setup and an access phase.
	task automatic reg_write(input puew_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MODES: modes_shadow = val[3:0];
			REG_RATIO: ratio_shadow = val[15:0];
			default:   mag_shadow = val[0];
		endcase
	endtask

	task automatic write_all(input logic [3:0] m, input logic [15:0] r, input logic g);
		reg_write(REG_MODES, 32'(m));
		reg_write(REG_RATIO, 32'(r));
		reg_write(REG_MAGP, 32'(g));
	endtask

	// Drain the pipeline before any register changes.
	task automatic settle();
		while (pending != 0 || din.valid) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Present one edge word; hold it until the block takes it.
	task automatic send_edge(input logic ev, input logic [15:0] ph, pn, pb, pa,
			input logic op, input logic [15:0] sh, sn, mh, mn);
		while ($urandom_range(99) < src_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.edge_valid <= ev;
		din.phase_here <= ph; din.phase_next <= pn;
		din.phase_before <= pb; din.phase_after <= pa;
		din.outer_present <= op;
		din.second_phase_here <= sh; din.second_phase_next <= sn;
		din.magnitude_here <= mh; din.magnitude_next <= mn;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
	endtask

	task automatic stop_sending();
		din.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random edge: mostly smooth phases so coherence factors spread over their range.
	task automatic random_edge();
		logic [15:0] ph, pn, pb, pa, sh, sn, mh, mn;
		int d;
		ph = 16'($urandom);
		d = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4000);
		pn = ph + 16'(d) - 16'd2000;
		pb = ph - (pn - ph) + 16'($urandom_range(1000)) - 16'd500;
		pa = pn + (pn - ph) + 16'($urandom_range(1000)) - 16'd500;
		if ($urandom_range(4) == 0) begin
			pb = 16'($urandom); pa = 16'($urandom);
		end
		sh = 16'($urandom);
		sn = $urandom_range(1) ? sh - 16'((pn - ph) * 2) + 16'($urandom_range(600))
			: 16'($urandom);
		mh = 16'($urandom);
		case ($urandom_range(5))
			0: mn = 16'd0;
			1: mn = mh;
			2: mn = mh + 16'($urandom_range(64));
			default: mn = 16'($urandom);
		endcase
		if ($urandom_range(15) == 0) mh = 16'd0;
		send_edge($urandom_range(9) != 0, ph, pn, pb, pa, $urandom_range(7) != 0,
			sh, sn, mh, mn);
	endtask

	initial begin
		logic [3:0] m;
		logic [15:0] r;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		din.valid = 1'b0; din.edge_valid = 1'b0;
		din.phase_here = '0; din.phase_next = '0; din.phase_before = '0;
		din.phase_after = '0; din.outer_present = 1'b0;
		din.second_phase_here = '0; din.second_phase_next = '0;
		din.magnitude_here = '0; din.magnitude_next = '0;
		modes_shadow = 4'd13; ratio_shadow = 16'd2048; mag_shadow = 1'b0;
		src_idle_pct = 36; snk_idle_pct = 87;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges under the reset settings, then with everything enabled.
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) write_all(4'hF, 16'd4096, 1'b1);
			send_edge(1'b0, 16'h7FFF, 16'h8000, 16'h0, 16'h0, 1'b1, 16'h0, 16'h0,
				16'd5, 16'd5);
			send_edge(1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0, 16'h0,
				16'hFFFF, 16'hFFFF);
			send_edge(1'b1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1,
				16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001);
			send_edge(1'b1, 16'd12868, 16'hCDBC, 16'h0, 16'h0, 1'b0,
				16'h8000, 16'h7FFF, 16'h0, 16'h0);
			send_edge(1'b1, 16'h1000, 16'h1400, 16'h0C00, 16'h1800, 1'b1,
				16'h2000, 16'h2800, 16'h0, 16'h1234);
			send_edge(1'b1, 16'hFFFF, 16'h0001, 16'hFFFD, 16'h0003, 1'b0,
				16'h0, 16'hFFFF, 16'h8000, 16'h7FFF);
			stop_sending();
			settle();
		end
		// No factors enabled at maximum ratio, then the gradient factor alone at ratio zero.
		write_all(4'h0, 16'hFFFF, 1'b0);
		send_edge(1'b1, 16'h1234, 16'h8765, 16'h0, 16'h0, 1'b1, 16'h0, 16'h0,
			16'd0, 16'd0);
		stop_sending();
		settle();
		write_all(4'h2, 16'd0, 1'b0);
		send_edge(1'b1, 16'h1234, 16'h1200, 16'h0, 16'h0, 1'b1, 16'h4000, 16'hC000,
			16'd0, 16'd0);
		stop_sending();
		settle();

		// Random phases: each under a fresh register setting, idling varied.
		for (int phase = 0; phase < 12; phase++) begin
			case (phase / 4)
				0: begin src_idle_pct = 36; snk_idle_pct = 87; end
				1: begin src_idle_pct = 87; snk_idle_pct = 36; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			m = (phase % 4 == 0) ? 4'hF : 4'($urandom);
			case (phase % 3)
				0: r = 16'($urandom_range(8192));
				1: r = 16'hFFFF;
				default: r = 16'($urandom);
			endcase
			write_all(m, r, $urandom_range(3) != 0);
			for (int k = 0; k < 104; k++) random_edge();
			stop_sending();
			settle();
		end

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

`default_nettype wire
